// ===== design/mdt_pkg.sv =====
`timescale 1ns / 1ps
package mdt_pkg;

	localparam int MAX_EV   = 5;
	localparam int EV_IDX_W = $clog2(MAX_EV + 1);
	localparam int Q_DEPTH  = 4;
	localparam int Q_PTR_W  = $clog2(Q_DEPTH);
	localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] MODE_LINE    = 2'd0;
	localparam logic [1:0] MODE_COMMENT = 2'd1;
	localparam logic [1:0] MODE_OUTPUT  = 2'd2;
	localparam logic [1:0] MODE_INPUTS  = 2'd3;

	localparam logic [2:0] EV_OUT_CHAR  = 3'd0;
	localparam logic [2:0] EV_OUT_END   = 3'd1;
	localparam logic [2:0] EV_IN_CHAR   = 3'd2;
	localparam logic [2:0] EV_IN_END    = 3'd3;
	localparam logic [2:0] EV_RULE_END  = 3'd4;
	localparam logic [2:0] EV_ERROR     = 3'd5;
	localparam logic [2:0] EV_DONE      = 3'd6;
	localparam logic [2:0] EV_DISCARD   = 3'd7;

	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_BSL     = 8'h5C;
	localparam logic [7:0] CH_NL      = 8'h0A;

	typedef struct packed {
		logic [1:0] mode;
		logic       pwb;   // previous byte was a backslash
		logic       bp;    // backslash held back
		logic       tok;   // name open
		logic       rho;   // rule has an output
		logic       err;
	} pstate_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] ch;
	} event_t;

	typedef struct packed {
		event_t [MAX_EV-1:0]  ev;
		logic [EV_IDX_W-1:0] cnt;
	} bundle_t;

	typedef struct packed {
		pstate_t st;
		bundle_t b;
	} work_t;

	function automatic work_t ev_add(work_t w, logic [2:0] kind, logic [7:0] ch);
		work_t r;
		r = w;
		if (r.b.cnt < EV_IDX_W'(MAX_EV)) begin
			r.b.ev[r.b.cnt].kind = kind;
			r.b.ev[r.b.cnt].ch   = (kind == EV_OUT_CHAR || kind == EV_IN_CHAR) ? ch : 8'h00;
			r.b.cnt = r.b.cnt + 1'b1;
		end
		return r;
	endfunction

	function automatic logic [2:0] char_kind(logic [1:0] mode);
		return (mode == MODE_OUTPUT) ? EV_OUT_CHAR : EV_IN_CHAR;
	endfunction

	function automatic work_t raise_err(work_t w);
		work_t r;
		r = ev_add(w, EV_ERROR, 8'h00);
		r.st.err = 1'b1;
		return r;
	endfunction

	function automatic work_t flush_bs(work_t w);
		work_t r;
		r = w;
		if (r.st.bp) begin
			r = ev_add(r, char_kind(r.st.mode), CH_BSL);
			r.st.bp  = 1'b0;
			r.st.tok = 1'b1;
		end
		return r;
	endfunction

	function automatic work_t end_in(work_t w);
		work_t r;
		r = w;
		if (r.st.tok) begin
			r = ev_add(r, EV_IN_END, 8'h00);
			r.st.tok = 1'b0;
		end
		return r;
	endfunction

	function automatic work_t append_ch(work_t w, logic [7:0] c);
		work_t r;
		r = flush_bs(w);
		if (c == CH_BSL) begin
			r.st.bp = 1'b1;
		end else begin
			r = ev_add(r, char_kind(r.st.mode), c);
			r.st.tok = 1'b1;
		end
		return r;
	endfunction

	function automatic work_t close_rule(work_t w);
		work_t r;
		r = w;
		if (r.st.rho) begin
			r = ev_add(r, EV_RULE_END, 8'h00);
			r.st.rho = 1'b0;
		end
		return r;
	endfunction

	// One byte: next state plus the events it causes, in order.
	function automatic work_t step(pstate_t s, logic [7:0] c, logic eos);
		work_t w;
		logic  esc;
		logic  sp;
		logic  named;
		w       = '0;
		w.st    = s;
		esc     = s.pwb;
		sp      = c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
		named   = (s.mode == MODE_OUTPUT) || (s.mode == MODE_INPUTS);
		if (!s.err) begin
			w.st.pwb = (c == CH_BSL);
			if (!esc && c == CH_HASH) begin
				if (s.mode == MODE_OUTPUT) begin
					w = ev_add(w, EV_DISCARD, 8'h00);
					w.st.tok = 1'b0;
					w.st.bp  = 1'b0;
				end else if (s.mode == MODE_INPUTS) begin
					w = end_in(w);
				end
				w.st.mode = MODE_COMMENT;
			end else if (!esc && c == CH_NL) begin
				if (s.mode == MODE_OUTPUT) begin
					w = raise_err(w);
				end else if (s.mode != MODE_LINE) begin
					w = end_in(w);
					w = close_rule(w);
					w.st.mode = MODE_LINE;
				end
			end else if (sp && (!esc || c == CH_NL)) begin
				if (s.mode == MODE_INPUTS) begin
					// escaped newline drops the held backslash
					if (esc)
						w.st.bp = 1'b0;
					w = end_in(w);
				end else if (s.mode == MODE_OUTPUT && esc) begin
					w = flush_bs(w);
				end
			end else if (!esc && c == CH_COLON) begin
				if (s.mode == MODE_OUTPUT) begin
					w = flush_bs(w);
					w = ev_add(w, EV_OUT_END, 8'h00);
					w.st.tok  = 1'b0;
					w.st.rho  = 1'b1;
					w.st.mode = MODE_INPUTS;
				end else if (s.mode != MODE_COMMENT) begin
					w = raise_err(w);
				end
			end else if (c == CH_HASH || c == CH_PERCENT || (esc && sp)) begin
				if (s.mode == MODE_LINE) begin
					w = raise_err(w);
				end else if (named) begin
					if (esc) begin
						w.st.bp  = 1'b0;
						w        = ev_add(w, char_kind(s.mode), c);
						w.st.tok = 1'b1;
					end else begin
						w = raise_err(w);
					end
				end
			end else begin
				if (s.mode == MODE_LINE) begin
					w.st.mode = MODE_OUTPUT;
					w = append_ch(w, c);
				end else if (named) begin
					w = append_ch(w, c);
				end
			end
		end
		if (eos) begin
			if (!w.st.err) begin
				if (w.st.mode == MODE_OUTPUT) begin
					w = raise_err(w);
				end else if (w.st.mode != MODE_LINE) begin
					w = flush_bs(w);
					w = end_in(w);
					w = close_rule(w);
				end
			end
			w = ev_add(w, EV_DONE, 8'h00);
			w.st = '0;
		end
		return w;
	endfunction

endpackage

// ===== design/mdt_front.sv =====
`timescale 1ns / 1ps
module mdt_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // data_byte
	input  logic             s_tlast,   // end_of_stream
	input  logic             q_full,
	output logic             q_push,
	output mdt_pkg::bundle_t q_data
);
	import mdt_pkg::*;

	pstate_t st_q;
	work_t   nxt;
	logic    acc;

	assign s_tready = !q_full;
	assign acc      = s_tvalid && s_tready;
	assign nxt      = step(st_q, s_tdata, s_tlast);
	assign q_data   = nxt.b;
	// bytes that cause no event take no queue slot
	assign q_push   = acc && (nxt.b.cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (acc) begin
			st_q <= nxt.st;
		end
	end

endmodule

// ===== design/mdt_queue.sv =====
`timescale 1ns / 1ps
module mdt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mdt_pkg::bundle_t wdata,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output mdt_pkg::bundle_t rdata
);
	import mdt_pkg::*;

	bundle_t             mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_q;
	logic [Q_PTR_W-1:0]  rd_q;
	logic [Q_CNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid) else $error("queue pop while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH)) else $error("queue count out of range");
	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (rdata.cnt != '0)) else $error("empty request in queue");

endmodule

// ===== design/mdt_back.sv =====
`timescale 1ns / 1ps
module mdt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  mdt_pkg::bundle_t q_data,
	output logic             q_pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // char_value
	output logic [2:0]       m_tuser,   // event_kind
	output logic             m_tlast    // last_of_run
);
	import mdt_pkg::*;

	logic [EV_IDX_W-1:0] idx_q;
	logic                vld_q;
	logic [2:0]          kind_q;
	logic [7:0]          ch_q;
	logic                last_q;
	logic                load;
	logic                is_last;

	assign load    = q_valid && (!vld_q || m_tready);
	assign is_last = (idx_q == q_data.cnt - 1'b1);
	assign q_pop   = load && is_last;

	assign m_tvalid = vld_q;
	assign m_tdata  = ch_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			vld_q <= 1'b1;
			idx_q <= is_last ? '0 : idx_q + 1'b1;
		end else if (m_tready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= q_data.ev[idx_q].kind;
			ch_q   <= q_data.ev[idx_q].ch;
			last_q <= is_last;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> (idx_q < q_data.cnt)) else $error("event index past request");
	a_idx_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (idx_q == '0)) else $error("index not rewound after pop");

endmodule

// ===== design/makefile_dependency_tokenizer.sv =====
`timescale 1ns / 1ps
// Dependency-file tokenizer. Bytes enter on the s_ stream at up to one per
// cycle (s_tlast marks the final byte of a file, which closes the stream and
// returns the parser to its reset state). Each byte causes zero to five
// events on the m_ stream, one event per cycle while m_tready is high, the
// last event of each byte flagged by m_tlast. The classifier updates the
// parse state per byte and hands each byte's non-empty event group to a
// four-entry queue; the serializer drains one event per cycle from the queue
// head while m_tready is high. A byte's events leave the output one by one,
// and the input keeps flowing until the queue fills. From byte to first
// event, a group passes through the queue and then the output register.
module makefile_dependency_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] data_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // [7:0] char_value
	output logic [2:0] m_tuser,    // [2:0] event_kind
	output logic       m_tlast
);
	import mdt_pkg::*;

	logic    q_full;
	logic    q_push;
	logic    q_pop;
	logic    q_valid;
	bundle_t q_wdata;
	bundle_t q_rdata;

	mdt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	mdt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	mdt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== tb/makefile_dependency_tokenizer_event_check.sv =====
`timescale 1ns / 1ps
module makefile_dependency_tokenizer_event_check (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] data_byte
	input  logic       s_tlast,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,    // [7:0] char_value
	input  logic [2:0] m_tuser,    // [2:0] event_kind
	input  logic       m_tlast,
	output int         fail_count,
	output int         pending
);
	import mdt_pkg::*;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] ch;
		logic       last;
	} dep_event_t;

	dep_event_t expected_events[$];
	dep_event_t byte_events[$];

	logic [1:0] mode;
	logic       after_bsl;
	logic       held_bsl;
	logic       name_open;
	logic       rule_open;
	logic       broken;

	task automatic clear_parser();
		mode      = MODE_LINE;
		after_bsl = 1'b0;
		held_bsl  = 1'b0;
		name_open = 1'b0;
		rule_open = 1'b0;
		broken    = 1'b0;
	endtask

	task automatic note_event(input logic [2:0] kind, input logic [7:0] ch);
		dep_event_t e;
		if (byte_events.size() < MAX_EV) begin
			e.kind = kind;
			e.ch   = (kind == EV_OUT_CHAR || kind == EV_IN_CHAR) ? ch : 8'h00;
			e.last = 1'b0;
			byte_events = {byte_events, e};
		end
	endtask

	function automatic logic [2:0] name_char_kind();
		return (mode == MODE_OUTPUT) ? EV_OUT_CHAR : EV_IN_CHAR;
	endfunction

	task automatic flag_error();
		note_event(EV_ERROR, 8'h00);
		broken = 1'b1;
	endtask

	task automatic emit_held_bsl();
		if (held_bsl) begin
			note_event(name_char_kind(), CH_BSL);
			held_bsl  = 1'b0;
			name_open = 1'b1;
		end
	endtask

	task automatic end_input_name();
		if (name_open) begin
			note_event(EV_IN_END, 8'h00);
			name_open = 1'b0;
		end
	endtask

	task automatic end_rule();
		if (rule_open) begin
			note_event(EV_RULE_END, 8'h00);
			rule_open = 1'b0;
		end
	endtask

	task automatic add_name_char(input logic [7:0] c);
		emit_held_bsl();
		if (c == CH_BSL) begin
			held_bsl = 1'b1;
		end else begin
			note_event(name_char_kind(), c);
			name_open = 1'b1;
		end
	endtask

	task automatic parse_byte(input logic [7:0] c);
		logic esc;
		logic blank;
		logic in_name;
		esc     = after_bsl;
		blank   = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
			(c == 8'h0C) || (c == 8'h0D);
		in_name = (mode == MODE_OUTPUT) || (mode == MODE_INPUTS);
		after_bsl = (c == CH_BSL);
		if (!esc && c == CH_HASH) begin
			// a comment cuts off a half-read output name
			if (mode == MODE_OUTPUT) begin
				note_event(EV_DISCARD, 8'h00);
				name_open = 1'b0;
				held_bsl  = 1'b0;
			end else if (mode == MODE_INPUTS) begin
				end_input_name();
			end
			mode = MODE_COMMENT;
		end else if (!esc && c == CH_NL) begin
			if (mode == MODE_OUTPUT) begin
				flag_error();
			end else if (mode != MODE_LINE) begin
				end_input_name();
				end_rule();
				mode = MODE_LINE;
			end
		end else if (blank && (!esc || c == CH_NL)) begin
			if (mode == MODE_INPUTS) begin
				// line continuation: drop the held backslash
				if (esc)
					held_bsl = 1'b0;
				end_input_name();
			end else if (mode == MODE_OUTPUT && esc) begin
				emit_held_bsl();
			end
		end else if (!esc && c == CH_COLON) begin
			if (mode == MODE_OUTPUT) begin
				emit_held_bsl();
				note_event(EV_OUT_END, 8'h00);
				name_open = 1'b0;
				rule_open = 1'b1;
				mode      = MODE_INPUTS;
			end else if (mode != MODE_COMMENT) begin
				flag_error();
			end
		end else if (c == CH_HASH || c == CH_PERCENT || (esc && blank)) begin
			if (mode == MODE_LINE) begin
				flag_error();
			end else if (in_name) begin
				if (esc) begin
					held_bsl = 1'b0;
					note_event(name_char_kind(), c);
					name_open = 1'b1;
				end else begin
					flag_error();
				end
			end
		end else begin
			if (mode == MODE_LINE) begin
				mode = MODE_OUTPUT;
				add_name_char(c);
			end else if (in_name) begin
				add_name_char(c);
			end
		end
	endtask

	task automatic predict_byte(input logic [7:0] c, input logic eos);
		dep_event_t e;
		byte_events.delete();
		if (!broken)
			parse_byte(c);
		if (eos) begin
			if (!broken) begin
				if (mode == MODE_OUTPUT) begin
					flag_error();
				end else if (mode != MODE_LINE) begin
					emit_held_bsl();
					end_input_name();
					end_rule();
				end
			end
			note_event(EV_DONE, 8'h00);
			clear_parser();
		end
		if (byte_events.size() > 0) begin
			e = byte_events[byte_events.size() - 1];
			e.last = 1'b1;
			byte_events[byte_events.size() - 1] = e;
		end
		foreach (byte_events[i])
			expected_events = {expected_events, byte_events[i]};
	endtask

	task automatic report_mismatch(input string field, input dep_event_t got,
		input dep_event_t want);
		$write("event mismatch on %s: got kind %0d char %02h last %0b, ",
			field, got.kind, got.ch, got.last);
		$display("want kind %0d char %02h last %0b", want.kind, want.ch, want.last);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		dep_event_t got;
		dep_event_t want;
		if (!arst_n) begin
			clear_parser();
			expected_events.delete();
			pending = 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				got.kind = m_tuser;
				got.ch   = m_tdata;
				got.last = m_tlast;
				if (expected_events.size() == 0) begin
					want = '0;
					report_mismatch("unexpected event", got, want);
				end else begin
					want = expected_events.pop_front();
					if (got.kind !== want.kind)
						report_mismatch("kind", got, want);
					if (got.ch !== want.ch)
						report_mismatch("char", got, want);
					if (got.last !== want.last)
						report_mismatch("last", got, want);
				end
			end
			pending = expected_events.size();
		end
	end

endmodule

// ===== tb/makefile_dependency_tokenizer_test.sv =====
`timescale 1ns / 1ps
module makefile_dependency_tokenizer_test;
	import mdt_pkg::*;

	localparam int TX_SIDE      = 0;
	localparam int RX_SIDE      = 1;
	localparam int RANDOM_ITEMS = 240;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;            // [7:0] char_value
	logic [2:0] m_tuser;            // [2:0] event_kind
	logic       m_tlast;

	int         fail_count;
	int         pending;
	int         calm_left[2];
	int         random_items;
	logic [7:0] text[$];

	always #2 clk = ~clk;

	makefile_dependency_tokenizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	makefile_dependency_tokenizer_event_check event_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Mostly short pauses, a few long ones, and now and then a calm stretch.
	function automatic int pick_pause(input int side);
		int r;
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			calm_left[side] = $urandom_range(20, 60);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	initial begin
		int hold;
		forever begin
			hold = pick_pause(RX_SIDE);
			if (hold == 0) begin
				@(negedge clk);
				m_tready <= 1'b1;
			end else begin
				repeat (hold) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_byte(input logic [7:0] c, input logic eos);
		int gap;
		gap = pick_pause(TX_SIDE);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eos;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_string(input string s, input logic close);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i], close && (i == s.len() - 1));
	endtask

	// Hold off until every pending event has come out.
	task automatic drain_wait();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic put_byte(input logic [7:0] b);
		text = {text, b};
	endtask

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		c = 8'($urandom_range(33, 126));
		if (c == CH_COLON || c == CH_HASH || c == CH_PERCENT || c == CH_BSL)
			c = "q";
		return c;
	endfunction

	task automatic put_name_char();
		int r;
		r = $urandom_range(0, 19);
		if (r < 10) begin
			put_byte(8'($urandom_range(97, 122)));
		end else if (r < 12) begin
			put_byte(plain_char());
		end else if (r == 12) begin
			put_byte(8'($urandom_range(128, 255)));
		end else if (r == 13) begin
			put_byte(8'h00);
		end else begin
			// escape sequences
			put_byte(CH_BSL);
			case (r)
				14: put_byte(" ");
				15: put_byte(CH_HASH);
				16: put_byte(CH_PERCENT);
				17: put_byte(8'h09);
				18: put_byte(($urandom_range(0, 1) == 0) ? CH_BSL : CH_COLON);
				default: put_byte(plain_char());
			endcase
		end
	endtask

	task automatic put_name(input int n);
		int i;
		for (i = 0; i < n; i++)
			put_name_char();
	endtask

	task automatic put_separator();
		case ($urandom_range(0, 6))
			0: begin
				put_byte(CH_BSL);
				put_byte(CH_NL);
			end
			1: put_byte(8'h09);
			2: put_byte(8'h0D);
			3: put_byte(8'h0B);
			4: put_byte(8'h0C);
			5: begin
				put_byte(" ");
				put_byte(" ");
			end
			default: put_byte(" ");
		endcase
	endtask

	task automatic put_comment();
		int n;
		n = $urandom_range(0, 4);
		put_byte(CH_HASH);
		repeat (n) put_byte(8'($urandom_range(32, 126)));
		put_byte(CH_NL);
	endtask

	task automatic put_rule();
		int k;
		if ($urandom_range(0, 3) == 0)
			put_byte(" ");
		put_name($urandom_range(1, 4));
		if ($urandom_range(0, 3) == 0)
			put_byte(8'h09);
		put_byte(CH_COLON);
		k = $urandom_range(0, 3);
		repeat (k) begin
			put_separator();
			put_name($urandom_range(1, 4));
		end
		if ($urandom_range(0, 4) == 0) begin
			put_separator();
			put_comment();
		end else begin
			put_byte(CH_NL);
		end
	endtask

	task automatic build_file();
		int lines;
		int r;
		text.delete();
		if ($urandom_range(0, 15) == 0) begin
			repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
		end else begin
			lines = $urandom_range(1, 3);
			repeat (lines) begin
				r = $urandom_range(0, 19);
				if (r < 2)
					put_byte(CH_NL);
				else if (r < 4)
					put_comment();
				else
					put_rule();
			end
			// let the end of the stream close the last rule
			if (text.size() > 1 && $urandom_range(0, 2) == 0)
				void'(text.pop_back());
			if ($urandom_range(0, 7) == 0)
				text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
		end
	endtask

	task automatic send_file();
		int i;
		for (i = 0; i < text.size(); i++)
			send_byte(text[i], i == text.size() - 1);
		random_items += text.size();
	endtask

	initial begin
		#2_000_000;
		$display("makefile_dependency_tokenizer_test NOT OK");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// both byte extremes, escapes in both names, continuation, comments,
		// then a colon at line start
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_string("\\ \\#\t:\\%\\\nq#\n:x", 1'b1);
		// output name cut by a comment, then a bare percent at line start
		send_string("a#\n%", 1'b1);
		// colon in the input list
		send_string("y::", 1'b1);
		// stream ends inside an output name
		send_string("z", 1'b1);
		drain_wait();

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0)
				drain_wait();
			build_file();
			send_file();
		end

		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (16) @(negedge clk);
		if (fail_count == 0)
			$display("makefile_dependency_tokenizer_test OK");
		else
			$display("makefile_dependency_tokenizer_test NOT OK");
		$finish;
	end

endmodule
